[hdl/pdl_pkg.sv]
// Shared types and constants of the password door lock controller.
// Used by the modules in hdl/ other than pdl_checker through scoped names; depends on nothing.
package pdl_pkg;

    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int OUT_TDATA_W = 8;

    // Command bytes seen while idle
    localparam logic [BYTE_W-1:0] CMD_SET_BYTE   = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_CHECK_BYTE = 8'h31;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b000_0001,
        M_SET   = 7'b000_0010,
        M_CHECK = 7'b000_0100,
        M_CW    = 7'b000_1000,
        M_PAUSE = 7'b001_0000,
        M_CCW   = 7'b010_0000,
        M_LOCK  = 7'b100_0000
    } t_mode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TICKS_PER_SECOND = 3'd0,
        CFG_OPEN_SECONDS     = 3'd1,
        CFG_PAUSE_SECONDS    = 3'd2,
        CFG_CLOSE_SECONDS    = 3'd3,
        CFG_LOCKOUT_SECONDS  = 3'd4,
        CFG_MAX_ATTEMPTS     = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        REPLY_WRONG    = 2'd0,
        REPLY_ACCEPTED = 2'd1,
        REPLY_LOCKED   = 2'd2
    } t_reply;

    typedef enum logic [1:0] {
        MOTOR_OFF = 2'd0,
        MOTOR_CW  = 2'd1,
        MOTOR_CCW = 2'd2
    } t_motor;

    typedef struct packed {
        logic [7:0] ticks_per_second;
        logic [5:0] open_seconds;
        logic [5:0] pause_seconds;
        logic [5:0] close_seconds;
        logic [7:0] lockout_seconds;
        logic [2:0] max_attempts;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ticks_per_second: 8'd123,
        open_seconds:     6'd16,
        pause_seconds:    6'd3,
        close_seconds:    6'd15,
        lockout_seconds:  8'd60,
        max_attempts:     3'd3
    };

    // Classified input word as it travels through the queue
    typedef struct packed {
        logic              tick;
        logic              cmd_set;
        logic              cmd_check;
        logic [BYTE_W-1:0] data;
    } t_item;

endpackage

[hdl/pdl_front.sv]
// Front end: takes input words and classifies them for the queue.
// Depends on pdl_pkg.
module pdl_front (
    input  logic                        i_tvalid,
    input  logic                        i_tuser,
    input  logic [pdl_pkg::BYTE_W-1:0]  i_tdata,
    output logic                        o_tready,
    input  logic                        i_full,
    output logic                        o_push,
    output pdl_pkg::t_item              o_item
);

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;

    always_comb begin
        o_item.tick      = i_tuser;
        o_item.cmd_set   = !i_tuser && (i_tdata == pdl_pkg::CMD_SET_BYTE);
        o_item.cmd_check = !i_tuser && (i_tdata == pdl_pkg::CMD_CHECK_BYTE);
        o_item.data      = i_tdata;
    end

endmodule

[hdl/pdl_queue.sv]
// Two-entry queue of classified words between front and back end.
// Depends on pdl_pkg.
module pdl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pdl_pkg::t_item  i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pdl_pkg::t_item  o_item
);

    pdl_pkg::t_item r_slot [2];
    logic           r_wr_ptr, n_wr_ptr;
    logic           r_rd_ptr, n_rd_ptr;
    logic [1:0]     r_count,  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + {1'b0, i_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

[hdl/pdl_back.sv]
// Back end: configuration registers, password store, lock sequencer and
// the output register. Depends on pdl_pkg.
module pdl_back #(
    parameter int PASS_LEN = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [pdl_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [pdl_pkg::BYTE_W-1:0]        i_cfg_data,
    input  logic                              i_q_valid,
    input  pdl_pkg::t_item                    i_q_item,
    output logic                              o_q_pop,
    output logic                              o_tvalid,
    input  logic                              i_tready,
    output logic [pdl_pkg::OUT_TDATA_W-1:0]   o_tdata
);

    localparam int IDX_W = (PASS_LEN > 1) ? $clog2(PASS_LEN) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PASS_LEN - 1);

    pdl_pkg::t_cfg   r_cfg;
    pdl_pkg::t_mode  r_mode, n_mode;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic            r_all_match, n_all_match;
    logic [2:0]      r_wrong, n_wrong;
    logic [7:0]      r_prescale, n_prescale;
    logic [7:0]      r_seconds, n_seconds;
    logic [7:0]      r_store [PASS_LEN];
    logic            store_we;

    logic            r_out_valid;
    logic [pdl_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic            timed;
    logic            byte_match;
    logic [2:0]      wrong_inc;
    logic [7:0]      prescale_inc;
    logic [7:0]      seconds_inc;
    logic            reply_valid;
    pdl_pkg::t_reply reply_code;
    pdl_pkg::t_motor motor;

    // Phase length in seconds of a timed mode
    function automatic logic [7:0] phase_len(pdl_pkg::t_mode m, pdl_pkg::t_cfg c);
        logic [7:0] len;
        len = 8'd1;
        if (m == pdl_pkg::M_CW)    len = {2'b00, c.open_seconds};
        if (m == pdl_pkg::M_PAUSE) len = {2'b00, c.pause_seconds};
        if (m == pdl_pkg::M_CCW)   len = {2'b00, c.close_seconds};
        if (m == pdl_pkg::M_LOCK)  len = c.lockout_seconds;
        return len;
    endfunction

    // Skip over timed phases of zero length
    function automatic pdl_pkg::t_mode settle(pdl_pkg::t_mode m, pdl_pkg::t_cfg c);
        pdl_pkg::t_mode s;
        s = m;
        if (s == pdl_pkg::M_CW && c.open_seconds == 6'd0)     s = pdl_pkg::M_PAUSE;
        if (s == pdl_pkg::M_PAUSE && c.pause_seconds == 6'd0) s = pdl_pkg::M_CCW;
        if (s == pdl_pkg::M_CCW && c.close_seconds == 6'd0)   s = pdl_pkg::M_IDLE;
        if (s == pdl_pkg::M_LOCK && c.lockout_seconds == 8'd0) s = pdl_pkg::M_IDLE;
        return s;
    endfunction

    function automatic pdl_pkg::t_mode phase_next(pdl_pkg::t_mode m);
        pdl_pkg::t_mode s;
        s = pdl_pkg::M_IDLE;
        if (m == pdl_pkg::M_CW)    s = pdl_pkg::M_PAUSE;
        if (m == pdl_pkg::M_PAUSE) s = pdl_pkg::M_CCW;
        return s;
    endfunction

    function automatic logic timed_flag(pdl_pkg::t_mode m);
        return (m == pdl_pkg::M_CW) || (m == pdl_pkg::M_PAUSE) ||
               (m == pdl_pkg::M_CCW) || (m == pdl_pkg::M_LOCK);
    endfunction

    assign o_q_pop  = i_q_valid && (!r_out_valid || i_tready);
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    assign timed        = (r_mode == pdl_pkg::M_CW) || (r_mode == pdl_pkg::M_PAUSE) ||
                          (r_mode == pdl_pkg::M_CCW) || (r_mode == pdl_pkg::M_LOCK);
    assign byte_match   = (r_store[r_idx] == i_q_item.data);
    assign wrong_inc    = r_wrong + 3'd1;
    assign prescale_inc = r_prescale + 8'd1;
    assign seconds_inc  = r_seconds + 8'd1;

    always_comb begin
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_all_match = r_all_match;
        n_wrong     = r_wrong;
        n_prescale  = r_prescale;
        n_seconds   = r_seconds;
        store_we    = 1'b0;
        reply_valid = 1'b0;
        reply_code  = pdl_pkg::REPLY_WRONG;
        if (o_q_pop) begin
            if (!i_q_item.tick) begin
                unique case (r_mode)
                    pdl_pkg::M_IDLE: begin
                        if (i_q_item.cmd_set) begin
                            n_mode = pdl_pkg::M_SET;
                            n_idx  = '0;
                        end else if (i_q_item.cmd_check) begin
                            n_mode      = pdl_pkg::M_CHECK;
                            n_idx       = '0;
                            n_all_match = 1'b1;
                        end
                    end
                    pdl_pkg::M_SET: begin
                        store_we = 1'b1;
                        if (r_idx == LAST_IDX) begin
                            n_mode = pdl_pkg::M_IDLE;
                            n_idx  = '0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    pdl_pkg::M_CHECK: begin
                        if (r_idx == LAST_IDX) begin
                            reply_valid = 1'b1;
                            n_idx       = '0;
                            n_all_match = 1'b1;
                            n_prescale  = 8'd0;
                            n_seconds   = 8'd0;
                            if (r_all_match && byte_match) begin
                                reply_code = pdl_pkg::REPLY_ACCEPTED;
                                n_mode     = settle(pdl_pkg::M_CW, r_cfg);
                            end else begin
                                n_wrong = wrong_inc;
                                if (wrong_inc >= r_cfg.max_attempts) begin
                                    reply_code = pdl_pkg::REPLY_LOCKED;
                                    n_mode     = settle(pdl_pkg::M_LOCK, r_cfg);
                                    // A lockout of no length ends at once
                                    if (r_cfg.lockout_seconds == 8'd0) begin
                                        n_wrong = 3'd0;
                                    end
                                end
                            end
                        end else begin
                            n_idx       = r_idx + 1'b1;
                            n_all_match = r_all_match && byte_match;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (timed) begin
                if (prescale_inc == r_cfg.ticks_per_second) begin
                    n_prescale = 8'd0;
                    if (seconds_inc >= phase_len(r_mode, r_cfg)) begin
                        n_seconds = 8'd0;
                        n_mode    = settle(phase_next(r_mode), r_cfg);
                        if (r_mode == pdl_pkg::M_LOCK) begin
                            n_wrong = 3'd0;
                        end
                    end else begin
                        n_seconds = seconds_inc;
                    end
                end else begin
                    n_prescale = prescale_inc;
                end
            end
        end
    end

    always_comb begin
        motor = pdl_pkg::MOTOR_OFF;
        if (n_mode == pdl_pkg::M_CW)  motor = pdl_pkg::MOTOR_CW;
        if (n_mode == pdl_pkg::M_CCW) motor = pdl_pkg::MOTOR_CCW;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= pdl_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (pdl_pkg::t_cfg_index'(i_cfg_index))
                pdl_pkg::CFG_TICKS_PER_SECOND: r_cfg.ticks_per_second <= i_cfg_data;
                pdl_pkg::CFG_OPEN_SECONDS:     r_cfg.open_seconds     <= i_cfg_data[5:0];
                pdl_pkg::CFG_PAUSE_SECONDS:    r_cfg.pause_seconds    <= i_cfg_data[5:0];
                pdl_pkg::CFG_CLOSE_SECONDS:    r_cfg.close_seconds    <= i_cfg_data[5:0];
                pdl_pkg::CFG_LOCKOUT_SECONDS:  r_cfg.lockout_seconds  <= i_cfg_data;
                pdl_pkg::CFG_MAX_ATTEMPTS:     r_cfg.max_attempts     <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= pdl_pkg::M_IDLE;
            r_idx       <= '0;
            r_all_match <= 1'b1;
            r_wrong     <= 3'd0;
            r_prescale  <= 8'd0;
            r_seconds   <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_idx       <= n_idx;
            r_all_match <= n_all_match;
            r_wrong     <= n_wrong;
            r_prescale  <= n_prescale;
            r_seconds   <= n_seconds;
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PASS_LEN; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (store_we) begin
            r_store[r_idx] <= i_q_item.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_data <= {1'b0, timed_flag(n_mode), n_mode == pdl_pkg::M_LOCK,
                           motor, reply_code, reply_valid};
        end
    end

endmodule

[hdl/password_door_lock_controller.sv]
// Top level of the password door lock controller.
// Instantiates pdl_front, pdl_queue and pdl_back; depends on pdl_pkg.
//
// Usage
//   Input stream (s_axis): one word per received byte or timer tick.
//     tuser selects the kind (0 byte, 1 tick), tdata carries the byte.
//   Output stream (m_axis): exactly one result word per input word, in order.
//   Configuration channel (cfg): index 0..5 selects ticks per second, open,
//     pause, close and lockout seconds, and the wrong-attempt limit; the
//     channel is always ready. Write it only while no word is in flight.
//   Path: a result word passes through a queue entry, then the output register,
//     on its way to m_axis.
//   Throughput: one word per cycle while the receiver is ready, set by the sequencer step in
//     the back end; the front end and the back end meet at a two-entry queue.
//   Stall: while the receiver holds tready low, the output register holds its
//     word, the queue fills, and s_axis tready falls once both entries are
//     full; nothing is dropped.
//   Reset: clears the queue and output register, returns the sequencer to
//     idle, zeroes the password store and reloads configuration defaults.
module password_door_lock_controller #(
    parameter int PASS_LEN = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_value
    input  logic        i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] reply_valid, [2:1] reply_code,
                                          // [4:3] motor_drive, [5] buzzer,
                                          // [6] busy_res, [7] zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic           q_full;
    logic           q_push;
    pdl_pkg::t_item q_in_item;
    logic           q_pop;
    logic           q_valid;
    pdl_pkg::t_item q_out_item;

    // Configuration registers take a word on every cycle
    assign o_cfg_ready = 1'b1;

    // Front: classify the incoming word as tick, command or data byte
    pdl_front u_front (
        .i_tvalid (i_s_axis_tvalid),
        .i_tuser  (i_s_axis_tuser),
        .i_tdata  (i_s_axis_tdata),
        .o_tready (o_s_axis_tready),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_item   (q_in_item)
    );

    // Queue: decouple the input side from output back-pressure
    pdl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    // Back: advance the lock sequencer one word per cycle while the output register can take it, register the result
    pdl_back #(
        .PASS_LEN (PASS_LEN)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_item    (q_out_item),
        .o_q_pop     (q_pop),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_tdata     (o_m_axis_tdata)
    );

endmodule

[hdl/pdl_checker.sv]
// Port-level checker for the password door lock controller, bound to the
// top level. Depends on the top level's port list only.
module pdl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata
);

    // Hold a stalled result word
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result word dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("stalled result word changed");

    // No result word straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result word present after reset");

    // Buzzer and motor only run inside a busy sequence; never both at once; a reply code needs reply_valid
    a_fields_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (!o_m_axis_tdata[5] || (o_m_axis_tdata[6] && o_m_axis_tdata[4:3] == 2'd0)) &&
            (o_m_axis_tdata[4:3] == 2'd0 || o_m_axis_tdata[6]) &&
            (o_m_axis_tdata[0] || o_m_axis_tdata[2:1] == 2'd0))
        else $error("inconsistent result fields");

endmodule

bind password_door_lock_controller pdl_checker u_pdl_checker (.*);

[tb/password_door_lock_controller_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench of password_door_lock_controller: a bit-exact
// predictor of the lock sequencer checks every result word against the DUT.
// Depends on pdl_pkg and the RTL in hdl/; needs no files or arguments.
module password_door_lock_controller_test;

    localparam int PASS_LEN     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int TAIL_CYCLES  = 8;       // tail after the drain, so a stray word is still caught
    localparam int CYCLE_LIMIT  = 500_000;
    localparam int RANDOM_WORDS = 600;

    // One result word, members from the top bit down so that the struct
    // overlays tdata[6:0] directly.
    typedef struct packed {
        logic            busy_res;
        logic            buzzer;
        pdl_pkg::t_motor motor_drive;
        pdl_pkg::t_reply reply_code;
        logic            reply_valid;
    } t_door_word;

    // DUT inputs, all known from time zero
    logic       i_clk           = 1'b0;
    logic       i_rst_n         = 1'b0;
    logic       i_s_axis_tvalid = 1'b0;
    logic [7:0] i_s_axis_tdata  = '0;
    logic       i_s_axis_tuser  = 1'b0;
    logic       i_m_axis_tready = 1'b1;
    logic       i_cfg_valid     = 1'b0;
    logic [2:0] i_cfg_index     = '0;
    logic [7:0] i_cfg_data      = '0;

    logic       o_s_axis_tready;
    logic       o_m_axis_tvalid;
    logic [7:0] o_m_axis_tdata;
    logic       o_cfg_ready;

    // Predictor state: a private copy of the sequencer and its registers
    pdl_pkg::t_cfg  door_cfg;
    pdl_pkg::t_mode door_mode;
    logic [2:0]     pos_q;
    logic [2:0]     hits_q;
    logic [2:0]     wrong_q;
    logic [7:0]     prescale_q;
    logic [7:0]     secs_q;
    logic [7:0]     pw_store [PASS_LEN];

    // Expected result words, oldest first
    t_door_word door_words [$];

    logic [7:0] attempt_bytes [PASS_LEN];
    logic       attempt_ready = 1'b0;
    logic       gaps_on       = 1'b1;
    int         stall_left    = 0;
    int         live_words    = 0;
    int         errors        = 0;
    int         cycle_count;

    password_door_lock_controller #(
        .PASS_LEN(PASS_LEN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void model_reset();
        door_cfg   = pdl_pkg::CFG_RESET;
        door_mode  = pdl_pkg::M_IDLE;
        pos_q      = '0;
        hits_q     = '0;
        wrong_q    = '0;
        prescale_q = '0;
        secs_q     = '0;
        foreach (pw_store[i]) pw_store[i] = '0;
    endfunction

    function automatic logic timed_mode(pdl_pkg::t_mode m);
        return m inside {pdl_pkg::M_CW, pdl_pkg::M_PAUSE, pdl_pkg::M_CCW, pdl_pkg::M_LOCK};
    endfunction

    function automatic logic [7:0] phase_seconds(pdl_pkg::t_mode m);
        case (m)
            pdl_pkg::M_CW:    return {2'b00, door_cfg.open_seconds};
            pdl_pkg::M_PAUSE: return {2'b00, door_cfg.pause_seconds};
            pdl_pkg::M_CCW:   return {2'b00, door_cfg.close_seconds};
            pdl_pkg::M_LOCK:  return door_cfg.lockout_seconds;
            default:          return 8'd1;
        endcase
    endfunction

    // Leaving the lockout is the only thing that forgives wrong attempts
    function automatic pdl_pkg::t_mode phase_after(pdl_pkg::t_mode m);
        case (m)
            pdl_pkg::M_CW:    return pdl_pkg::M_PAUSE;
            pdl_pkg::M_PAUSE: return pdl_pkg::M_CCW;
            pdl_pkg::M_LOCK: begin
                wrong_q = '0;
                return pdl_pkg::M_IDLE;
            end
            default: return pdl_pkg::M_IDLE;
        endcase
    endfunction

    // Enter a timed phase, skip any of zero length, restart the prescaler
    function automatic void start_phase(pdl_pkg::t_mode m);
        while (timed_mode(m) && phase_seconds(m) == 8'd0)
            m = phase_after(m);
        door_mode  = m;
        prescale_q = '0;
        secs_q     = '0;
    endfunction

    // Advance the predictor by one input word and return the result word.
    // ignored is set for words that leave the state as it was.
    function automatic t_door_word door_step(input logic func, input logic [7:0] b,
                                             output logic ignored);
        t_door_word w;
        logic       was_timed;
        w         = '0;
        was_timed = timed_mode(door_mode);
        ignored   = 1'b0;
        if (!func) begin
            case (door_mode)
                pdl_pkg::M_IDLE: begin
                    if (b == pdl_pkg::CMD_SET_BYTE) begin
                        door_mode = pdl_pkg::M_SET;
                        pos_q     = '0;
                    end else if (b == pdl_pkg::CMD_CHECK_BYTE) begin
                        door_mode = pdl_pkg::M_CHECK;
                        pos_q     = '0;
                        hits_q    = '0;
                    end else begin
                        ignored = 1'b1;
                    end
                end
                pdl_pkg::M_SET: begin
                    if (pos_q < PASS_LEN) pw_store[pos_q] = b;
                    pos_q = pos_q + 3'd1;
                    if (pos_q >= PASS_LEN) begin
                        door_mode = pdl_pkg::M_IDLE;
                        pos_q     = '0;
                    end
                end
                pdl_pkg::M_CHECK: begin
                    if (pos_q < PASS_LEN && pw_store[pos_q] == b) hits_q = hits_q + 3'd1;
                    pos_q = pos_q + 3'd1;
                    if (pos_q >= PASS_LEN) begin
                        w.reply_valid = 1'b1;
                        pos_q         = '0;
                        if (hits_q == PASS_LEN) begin
                            hits_q       = '0;
                            w.reply_code = pdl_pkg::REPLY_ACCEPTED;
                            start_phase(pdl_pkg::M_CW);
                        end else begin
                            // a miss stays in check mode for the next attempt
                            wrong_q = wrong_q + 3'd1;
                            hits_q  = '0;
                            if (wrong_q >= door_cfg.max_attempts) begin
                                w.reply_code = pdl_pkg::REPLY_LOCKED;
                                start_phase(pdl_pkg::M_LOCK);
                            end else begin
                                w.reply_code = pdl_pkg::REPLY_WRONG;
                            end
                        end
                    end
                end
                default: ignored = 1'b1;
            endcase
        end else if (was_timed) begin
            prescale_q = prescale_q + 8'd1;
            if (prescale_q == door_cfg.ticks_per_second) begin
                prescale_q = '0;
                secs_q     = secs_q + 8'd1;
                if (secs_q >= phase_seconds(door_mode)) start_phase(phase_after(door_mode));
            end
        end else begin
            ignored = 1'b1;
        end
        w.motor_drive = (door_mode == pdl_pkg::M_CW)  ? pdl_pkg::MOTOR_CW :
                        (door_mode == pdl_pkg::M_CCW) ? pdl_pkg::MOTOR_CCW :
                                                        pdl_pkg::MOTOR_OFF;
        w.buzzer      = (door_mode == pdl_pkg::M_LOCK);
        w.busy_res    = timed_mode(door_mode);
        return w;
    endfunction

    // Fill attempt_bytes with the stored password, or a copy that differs in
    // at least one byte.
    function automatic void make_attempt(logic right);
        int miss;
        foreach (attempt_bytes[i]) attempt_bytes[i] = pw_store[i];
        if (!right) begin
            miss = $urandom_range(0, PASS_LEN - 1);
            attempt_bytes[miss] = attempt_bytes[miss] ^ 8'($urandom_range(1, 255));
            foreach (attempt_bytes[i])
                if (i != miss && $urandom_range(0, 3) == 0)
                    attempt_bytes[i] = 8'($urandom_range(0, 255));
        end
    endfunction

    // Phase length with random bits above the 6-bit field, which drop off
    function automatic logic [7:0] short_seconds();
        logic [7:0] v;
        v      = 8'($urandom_range(0, 3));
        v[7:6] = 2'($urandom_range(0, 3));
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver back-pressure
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string field, input int want, input int got);
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
    endtask

    task automatic compare_word(input t_door_word want, input logic [7:0] got);
        t_door_word seen;
        seen = t_door_word'(got[6:0]);
        if (seen.reply_valid !== want.reply_valid)
            flag_mismatch("reply_valid", want.reply_valid, seen.reply_valid);
        if (seen.reply_code !== want.reply_code)
            flag_mismatch("reply_code", want.reply_code, seen.reply_code);
        if (seen.motor_drive !== want.motor_drive)
            flag_mismatch("motor_drive", want.motor_drive, seen.motor_drive);
        if (seen.buzzer !== want.buzzer)
            flag_mismatch("buzzer", want.buzzer, seen.buzzer);
        if (seen.busy_res !== want.busy_res)
            flag_mismatch("busy_res", want.busy_res, seen.busy_res);
        if (got[7] !== 1'b0)
            flag_mismatch("tdata pad bit", 0, got[7]);
    endtask

    // Take each result word against the oldest expectation, then decide
    // whether to hold tready low for a burst of random length.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (door_words.size() == 0) begin
                $error("result word 0x%02h arrived with none expected", o_m_axis_tdata);
                errors++;
            end else begin
                compare_word(door_words.pop_front(), o_m_axis_tdata);
            end
        end
        if (stall_left != 0)
            stall_left--;
        else if (gaps_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 5);
        i_m_axis_tready <= (stall_left == 0);
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one word, optionally after a sender gap, and predict it once taken.
    // tvalid is left high so back-to-back words need no second assignment.
    task automatic send_word(input logic func, input logic [7:0] b);
        t_door_word w;
        logic       ignored;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        i_s_axis_tuser  <= func;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        w = door_step(func, b, ignored);
        door_words.push_back(w);
        if (!ignored) live_words++;
    endtask

    // Drop tvalid and hold until every expected word has come back
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (door_words.size() != 0);
    endtask

    // Write one register; valid stays high for a following write
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pdl_pkg::CFG_TICKS_PER_SECOND: door_cfg.ticks_per_second = data;
            pdl_pkg::CFG_OPEN_SECONDS:     door_cfg.open_seconds     = data[5:0];
            pdl_pkg::CFG_PAUSE_SECONDS:    door_cfg.pause_seconds    = data[5:0];
            pdl_pkg::CFG_CLOSE_SECONDS:    door_cfg.close_seconds    = data[5:0];
            pdl_pkg::CFG_LOCKOUT_SECONDS:  door_cfg.lockout_seconds  = data;
            pdl_pkg::CFG_MAX_ATTEMPTS:     door_cfg.max_attempts     = data[2:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] tps, input logic [7:0] open_s,
                               input logic [7:0] pause_s, input logic [7:0] close_s,
                               input logic [7:0] lock_s, input logic [7:0] attempts);
        wait_drained();
        write_reg(pdl_pkg::CFG_TICKS_PER_SECOND, tps);
        write_reg(pdl_pkg::CFG_OPEN_SECONDS, open_s);
        write_reg(pdl_pkg::CFG_PAUSE_SECONDS, pause_s);
        write_reg(pdl_pkg::CFG_CLOSE_SECONDS, close_s);
        write_reg(pdl_pkg::CFG_LOCKOUT_SECONDS, lock_s);
        write_reg(pdl_pkg::CFG_MAX_ATTEMPTS, attempts);
        i_cfg_valid <= 1'b0;
    endtask

    // One password attempt; open a check first when the lock is idle
    task automatic check_attempt(input logic right);
        if (door_mode == pdl_pkg::M_IDLE) send_word(1'b0, pdl_pkg::CMD_CHECK_BYTE);
        make_attempt(right);
        for (int i = 0; i < PASS_LEN; i++) send_word(1'b0, attempt_bytes[i]);
    endtask

    // Tick until the door or the lockout sequence is over
    task automatic run_door();
        while (timed_mode(door_mode)) send_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle lock: a tick and a byte that is no command change nothing
    task automatic test_idle_noise();
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'hFF);
    endtask

    // Store a password, then lock out on the first miss with no attempts
    // allowed; one short lockout second returns the lock to idle.
    task automatic test_store_and_lockout();
        load_config(8'd1, 8'd1, 8'd0, 8'd1, 8'd1, 8'd0);
        send_word(1'b0, pdl_pkg::CMD_SET_BYTE);
        send_word(1'b0, 8'hFF);
        send_word(1'b0, 8'h00);
        send_word(1'b0, 8'hA5);
        send_word(1'b0, 8'h5A);
        send_word(1'b0, pdl_pkg::CMD_CHECK_BYTE);
        check_attempt(1'b0);
        run_door();
    endtask

    // Right password: open, skipped pause, close; a byte while busy has no effect
    task automatic test_door_cycle();
        load_config(8'd1, 8'd1, 8'd0, 8'd1, 8'd1, 8'd2);
        check_attempt(1'b1);
        send_word(1'b0, pdl_pkg::CMD_SET_BYTE);
        run_door();
    endtask

    // Zero ticks per second: the prescaler wraps, so a second is 256 ticks.
    // The pause value carries only bits above its field and reads as zero.
    task automatic test_prescaler_wrap();
        load_config(8'd0, 8'd1, 8'hC0, 8'd1, 8'd1, 8'd3);
        check_attempt(1'b1);
        run_door();
    endtask

    // All-ones write to every index, spare ones included; run a second at 255
    // ticks per second, shorten the phases mid-sequence, then use up seven
    // attempts.
    task automatic test_register_extremes();
        wait_drained();
        for (int idx = 0; idx < 2**pdl_pkg::CFG_INDEX_W; idx++)
            write_reg(idx[pdl_pkg::CFG_INDEX_W-1:0], 8'hFF);
        i_cfg_valid <= 1'b0;
        check_attempt(1'b1);
        repeat (260) send_word(1'b1, 8'($urandom_range(0, 255)));
        load_config(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd7);
        run_door();
        while (door_mode != pdl_pkg::M_LOCK) check_attempt(1'b0);
        run_door();
    endtask

    // Mostly well-formed sessions with random content: store, check right or
    // wrong, ride out the timed phases; ticks and stray bytes mixed in.
    task automatic test_random_sessions();
        int start_count;
        int pick;
        start_count = live_words;
        while (live_words - start_count < RANDOM_WORDS) begin
            // the closing stretch runs with no gaps on either side
            if (live_words - start_count >= RANDOM_WORDS * 4 / 5)
                gaps_on = 1'b0;
            else if ($urandom_range(0, 99) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 59) == 0)
                load_config(8'($urandom_range(1, 4)), short_seconds(), short_seconds(),
                            short_seconds(), 8'($urandom_range(0, 3)),
                            8'($urandom_range(0, 255)));
            case (door_mode)
                pdl_pkg::M_IDLE: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        send_word(1'b0, pdl_pkg::CMD_SET_BYTE);
                    else if (pick < 8)
                        send_word(1'b0, pdl_pkg::CMD_CHECK_BYTE);
                    else
                        send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
                end
                pdl_pkg::M_SET: begin
                    if ($urandom_range(0, 19) == 0)
                        send_word(1'b1, 8'($urandom_range(0, 255)));
                    else
                        send_word(1'b0, 8'($urandom_range(0, 255)));
                end
                pdl_pkg::M_CHECK: begin
                    if (!attempt_ready) begin
                        make_attempt(1'($urandom_range(0, 1)));
                        attempt_ready = 1'b1;
                    end
                    if ($urandom_range(0, 19) == 0)
                        send_word(1'b1, 8'($urandom_range(0, 255)));
                    else
                        send_word(1'b0, attempt_bytes[pos_q]);
                    if (door_mode != pdl_pkg::M_CHECK || pos_q == 0) attempt_ready = 1'b0;
                end
                default: begin
                    if ($urandom_range(0, 9) == 0)
                        send_word(1'b0, 8'($urandom_range(0, 255)));
                    else
                        send_word(1'b1, 8'($urandom_range(0, 255)));
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------

    initial begin
        model_reset();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_noise();
        test_store_and_lockout();
        test_door_cycle();
        test_prescaler_wrap();
        test_register_extremes();
        test_random_sessions();

        // drain, then hold for TAIL_CYCLES so a stray word would still be caught
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: end a hung run
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
